// ===== rtl/lcr_pkg.sv =====
package lcr_pkg;

   localparam int LCR_LINE_PIXELS = 128;
   localparam int LCR_SAMPLE_W    = 16;
   localparam int LCR_INDEX_W     = 7;
   localparam int LCR_RSP_DATA_W  = 32;

   typedef enum logic {
      LCR_MODE_TICK  = 1'b0,
      LCR_MODE_START = 1'b1
   } lcr_mode_type;

   typedef struct packed {
      lcr_mode_type            mode;
      logic [LCR_SAMPLE_W-1:0] adc_sample;
   } lcr_item_type;

   typedef struct packed {
      logic                    clk_level;
      logic                    si_level;
      logic                    pixel_valid;
      logic [LCR_INDEX_W-1:0]  pixel_index;
      logic [LCR_SAMPLE_W-1:0] pixel_value;
      logic                    line_done;
   } lcr_result_type;

endpackage

// ===== rtl/linescan_camera_readout_core.sv =====
// Line-scan sensor readout sequencer.
// req channel: one transaction per timer event. req_tuser = 0 is a clock tick,
// req_tuser = 1 arms the capture of one line; req_tdata carries the latest
// converter sample.
// rsp channel: exactly one transaction per req transaction, in order. It gives
// the sensor clock and SI pin levels, a captured pixel (tuser high, index and
// value in tdata) and tlast on the tick that ends the line and disarms.
// A line takes 2*LINE_PIXELS + 3 ticks after arming, LINE_PIXELS pixels.
// Each result is registered twice on its way from req to rsp: first in the input
// register, then in the result register.
// Throughput: one transaction per cycle while rsp_tready is high, set by the
// phase counter update.
// Reset: clock pin high, SI low, phase at -2, capture disarmed, both
// channels empty.
// When rsp_tready is low a valid result holds in the result register; the input
// register takes one more transaction if it is empty, then req_tready drops until rsp drains.
module linescan_camera_readout_core #(
   parameter int LINE_PIXELS = lcr_pkg::LCR_LINE_PIXELS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] adc_sample
   input  logic [lcr_pkg::LCR_SAMPLE_W-1:0]   req_tdata,
   // [0] mode
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] clk_level, [1] si_level, [8:2] pixel_index, [24:9] pixel_value, zero pad
   output logic [lcr_pkg::LCR_RSP_DATA_W-1:0] rsp_tdata,
   // [0] pixel_valid
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);
   import lcr_pkg::*;

   lcr_item_type   in_item;
   lcr_item_type   item;
   logic           item_valid;
   logic           out_ready;
   lcr_result_type result;
   lcr_result_type out_result;

   assign in_item.mode       = lcr_mode_type'(req_tuser);
   assign in_item.adc_sample = req_tdata;

   lcr_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .advance    (out_ready)
   );

   lcr_sequencer #(
      .LINE_PIXELS (LINE_PIXELS)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (out_ready),
      .result     (result)
   );

   lcr_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (item_valid && out_ready),
      .result     (result),
      .ready      (out_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tdata = LCR_RSP_DATA_W'({out_result.pixel_value, out_result.pixel_index,
                                        out_result.si_level, out_result.clk_level});
   assign rsp_tuser = out_result.pixel_valid;
   assign rsp_tlast = out_result.line_done;

`ifndef ASSERT_OFF
   a_done_clock_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[0])
      else $error("line done with sensor clock high");

   a_pixel_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[1])
      else $error("pixel captured with SI high");

   a_done_no_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser)
      else $error("line done and pixel capture in one transaction");

   a_item_drains: assert property (@(posedge clock) disable iff (reset)
      item_valid && out_ready |=> rsp_tvalid)
      else $error("advanced item produced no result");
`endif

endmodule

// ===== rtl/lcr_input_stage.sv =====
module lcr_input_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lcr_pkg::lcr_item_type in_item,
   output logic                 item_valid,
   output lcr_pkg::lcr_item_type item,
   input  logic                 advance
);
   import lcr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   lcr_item_type item_ff;

   assign in_ready   = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== rtl/lcr_sequencer.sv =====
module lcr_sequencer #(
   parameter int LINE_PIXELS = lcr_pkg::LCR_LINE_PIXELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  lcr_pkg::lcr_item_type   item,
   input  logic                   advance,
   output lcr_pkg::lcr_result_type result
);
   import lcr_pkg::*;

   localparam int PHASE_W = $clog2(2 * LINE_PIXELS + 1) + 1;
   localparam logic signed [PHASE_W-1:0] PHASE_START = -PHASE_W'(2);
   localparam logic signed [PHASE_W-1:0] PHASE_SI    = -PHASE_W'(1);
   localparam logic signed [PHASE_W-1:0] PHASE_ZERO  = PHASE_W'(0);
   localparam logic signed [PHASE_W-1:0] PHASE_TWO   = PHASE_W'(2);
   localparam logic signed [PHASE_W-1:0] PHASE_END   = PHASE_W'(2 * LINE_PIXELS);

   logic                      clock_level_ff, clock_level_in;
   logic                      select_level_ff, select_level_in;
   logic signed [PHASE_W-1:0] phase_count_ff, phase_count_in;
   logic                      capture_armed_ff, capture_armed_in;
   logic                      clk_toggled;
   logic [PHASE_W-1:0]        phase_half;

   assign clk_toggled = ~clock_level_ff;
   assign phase_half  = PHASE_W'(unsigned'(phase_count_ff)) >> 1;

   always_comb begin
      clock_level_in   = clock_level_ff;
      select_level_in  = select_level_ff;
      phase_count_in   = phase_count_ff;
      capture_armed_in = capture_armed_ff;
      result           = '0;
      if (item.mode == LCR_MODE_START) begin
         capture_armed_in = 1'b1;
      end else if (capture_armed_ff) begin
         clock_level_in = clk_toggled;
         if (phase_count_ff >= PHASE_TWO && phase_count_ff < PHASE_END) begin
            if (!clk_toggled) begin
               result.pixel_valid = 1'b1;
               result.pixel_index = LCR_INDEX_W'(phase_half);
               result.pixel_value = item.adc_sample;
            end
            phase_count_in = phase_count_ff + PHASE_W'(1);
         end else if (phase_count_ff < PHASE_TWO) begin
            if (phase_count_ff == PHASE_SI) begin
               select_level_in = 1'b1;
            end else if (phase_count_ff == PHASE_ZERO) begin
               select_level_in    = 1'b0;
               result.pixel_valid = 1'b1;
               result.pixel_value = item.adc_sample;
            end
            phase_count_in = phase_count_ff + PHASE_W'(1);
         end else begin
            clock_level_in   = 1'b0;
            phase_count_in   = PHASE_START;
            capture_armed_in = 1'b0;
            result.line_done = 1'b1;
         end
      end
      result.clk_level = clock_level_in;
      result.si_level  = select_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_level_ff   <= 1'b1;
         select_level_ff  <= 1'b0;
         phase_count_ff   <= PHASE_START;
         capture_armed_ff <= 1'b0;
      end else if (item_valid && advance) begin
         clock_level_ff   <= clock_level_in;
         select_level_ff  <= select_level_in;
         phase_count_ff   <= phase_count_in;
         capture_armed_ff <= capture_armed_in;
      end
   end

endmodule

// ===== rtl/lcr_output_stage.sv =====
module lcr_output_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  lcr_pkg::lcr_result_type result,
   output logic                   ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lcr_pkg::lcr_result_type out_result
);
   import lcr_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   lcr_result_type result_ff;

   assign ready      = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule
